>>> rtl/core/assert_macros.svh
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> rtl/core/modexp_pkg.sv
package modexp_pkg;
  localparam int unsigned InW  = 63;
  localparam int unsigned ResW = 30;
  localparam logic [ResW-1:0] Modp = 30'd1000000007;

  typedef logic [ResW-1:0] res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MSTART,
    ST_MWAIT,
    ST_DONE
  } state_t;
endpackage

>>> rtl/core/modexp_mul.sv
// Bit-serial modular multiplier, multiplier operand scanned MSB first.
module modexp_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  modexp_pkg::res_t      a,
  input  modexp_pkg::res_t      b,
  output logic                  done,
  output modexp_pkg::res_t      result
);
  import modexp_pkg::*;

  localparam int unsigned CntW = $clog2(ResW);

  res_t            a_r, b_r, r_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [ResW:0]   dbl, dbl_red, sum, sum_red;

  always_comb begin
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= {1'b0, Modp}) ? dbl - {1'b0, Modp} : dbl;
    sum     = dbl_red + (b_r[ResW-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, Modp}) ? sum - {1'b0, Modp} : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(ResW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= sum_red[ResW-1:0];
      b_r <= {b_r[ResW-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = r_r;
endmodule

>>> rtl/core/modular_exponentiation.sv
// Channel | Dir | Ports                              | Handshake
// in      | in  | in_base[62:0], in_exponent[62:0]   | in_valid / in_ready
// out     | out | out_power_mod[29:0]                | out_valid / out_ready
//
// One item at a time. Base reduction: one base bit per cycle.
// Each exponent bit up to the highest set one is handled by the two
// bit-serial 30-bit modular multipliers (result*square and square*square).
// Synchronous active-low reset returns to idle; out_ready low holds the result.
`include "assert_macros.svh"
module modular_exponentiation (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [modexp_pkg::InW-1:0] in_base,
  input  logic [modexp_pkg::InW-1:0] in_exponent,
  output logic                       out_valid,
  input  logic                       out_ready,
  output modexp_pkg::res_t           out_power_mod
);
  import modexp_pkg::*;

  localparam int unsigned BitW = $clog2(InW);

  state_t          state_r, state_nxt;
  logic [InW-1:0]  base_r, exp_r;
  logic [BitW-1:0] bit_r;
  res_t            acc_r, sq_r;
  logic [ResW:0]   red_dbl, red_val;
  logic            mul_start, acc_done, sq_done;
  res_t            acc_prod, sq_prod;

  // Shift-in reduction of the base: r = 2r + bit, one conditional subtract.
  always_comb begin
    red_dbl = {sq_r, base_r[InW-1]};
    red_val = (red_dbl >= {1'b0, Modp}) ? red_dbl - {1'b0, Modp} : red_dbl;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_REDUCE;
      ST_REDUCE: begin
        if (bit_r == '0) state_nxt = (exp_r == '0) ? ST_DONE : ST_MSTART;
      end
      ST_MSTART: state_nxt = ST_MWAIT;
      ST_MWAIT: begin
        if (acc_done) state_nxt = (exp_r[InW-1:1] == '0) ? ST_DONE : ST_MSTART;
      end
      ST_DONE:   if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    mul_start = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready  = 1'b1;
      ST_MSTART: mul_start = 1'b1;
      ST_DONE:   out_valid = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        base_r <= in_base;
        exp_r  <= in_exponent;
        bit_r  <= BitW'(InW - 1);
        sq_r   <= '0;
        acc_r  <= ResW'(1);
      end
      ST_REDUCE: begin
        sq_r   <= red_val[ResW-1:0];
        base_r <= {base_r[InW-2:0], 1'b0};
        bit_r  <= bit_r - 1'b1;
      end
      ST_MWAIT: begin
        if (acc_done) begin
          if (exp_r[0]) acc_r <= acc_prod;
          sq_r  <= sq_prod;
          exp_r <= {1'b0, exp_r[InW-1:1]};
        end
      end
      default: ;
    endcase
  end

  modexp_mul u_mul_acc (
    .clk, .rst_n, .start(mul_start), .a(acc_r), .b(sq_r),
    .done(acc_done), .result(acc_prod)
  );

  modexp_mul u_mul_sq (
    .clk, .rst_n, .start(mul_start), .a(sq_r), .b(sq_r),
    .done(sq_done), .result(sq_prod)
  );

  assign out_power_mod = acc_r;

  `ASSERT_IMPL(a_mul_sync, clk, rst_n, (acc_done == sq_done), "multipliers out of step")
  `ASSERT_IMPL(a_res_range, clk, rst_n, (out_valid |-> (acc_r < Modp)), "result not reduced")
  `ASSERT_NEXT(a_accept, clk, rst_n, (in_valid && in_ready), (state_r == ST_REDUCE),
               "accept did not start reduction")
endmodule
